[rtl/hlt_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hlt_pkg
// Shared types and codes for the heartbeat liveness table.
// ----------------------------------------------------------------------------
package hlt_pkg;

    localparam int unsigned KEY_W  = 32;
    localparam int unsigned TIME_W = 32;
    localparam int unsigned INT_W  = 16;
    localparam int unsigned MISS_W = 8;
    localparam int unsigned STAT_W = 3;
    localparam int unsigned IDX_W  = 5;
    localparam logic [MISS_W-1:0] MISS_SAT = 8'd255;

    typedef enum logic [1:0] {
        FUNC_BEAT  = 2'd0,
        FUNC_TICK  = 2'd1,
        FUNC_QUERY = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    typedef enum logic [STAT_W-1:0] {
        ST_REFRESHED = 3'd0,
        ST_INSERTED  = 3'd1,
        ST_FULL      = 3'd2,
        ST_INVALID   = 3'd3,
        ST_FOUND     = 3'd4,
        ST_NOT_FOUND = 3'd5,
        ST_SWEEP     = 3'd6,
        ST_EMPTY     = 3'd7
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_BEAT_WR,
        S_QRY_OUT,
        S_TICK_RD,
        S_TICK_DIV,
        S_TICK_WAIT,
        S_TICK_OUT,
        S_SINGLE
    } state_t;

endpackage
`default_nettype wire

[rtl/heartbeat_liveness_table.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// heartbeat_liveness_table
// Keyed device table with beat, tick sweep and query items.
// ----------------------------------------------------------------------------
// Beat/query search the slots in turn; tick sweeps each tracked slot through
// the bit-serial divider. One item at a time; busy falls in the cycle the
// last result is strobed, but stays high through the strobe of an invalid
// beat or an empty tick. Results are strobed for one cycle each; the receiver
// cannot stall. Reset: count and interval (10) reset; miss memory entries are
// written on insert before any read, so no clearing pass is needed.
module heartbeat_liveness_table
#(
    parameter int unsigned TABLE_ENTRIES = 32
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [1:0]                    func,
    input  wire logic [hlt_pkg::KEY_W-1:0]     device_key,
    input  wire logic [hlt_pkg::TIME_W-1:0]    now_time,
    input  wire logic                          cfg_we,
    input  wire logic [hlt_pkg::INT_W-1:0]     cfg_wdata,
    output logic                               done,
    output logic [hlt_pkg::STAT_W-1:0]         status,
    output logic [hlt_pkg::IDX_W-1:0]          entry_index,
    output logic [hlt_pkg::KEY_W-1:0]          entry_key,
    output logic [hlt_pkg::MISS_W-1:0]         miss_total,
    output logic [hlt_pkg::TIME_W-1:0]         last_seen,
    output logic                               alive,
    output logic                               last
);
    import hlt_pkg::*;

    localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_ENTRIES);

    state_t state_reg, state_next;

    logic [INT_W-1:0]  interval_reg;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     ptr_reg;
    logic [1:0]        func_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [TIME_W-1:0] now_reg;
    logic [TIME_W-1:0] seen_reg;
    logic [KEY_W-1:0]  skey_reg;

    logic              o_done_reg;
    logic [STAT_W-1:0] o_status_reg;
    logic [IDX_W-1:0]  o_idx_reg;
    logic [KEY_W-1:0]  o_key_reg;
    logic [MISS_W-1:0] o_miss_reg;
    logic [TIME_W-1:0] o_seen_reg;
    logic              o_alive_reg;
    logic              o_last_reg;

    logic [KEY_W-1:0]  rd_key;
    logic [TIME_W-1:0] rd_time;
    logic [MISS_W-1:0] rd_miss;
    logic              wr_en, wr_key_en, wr_miss_en;
    logic [AW-1:0]     wr_addr;
    logic [MISS_W-1:0] wr_miss;
    logic [AW-1:0]     rd_addr;

    logic              div_start, div_done;
    logic [TIME_W-1:0] div_q;
    logic [TIME_W-1:0] div_gap;
    logic [INT_W-1:0]  eff_int;
    logic [MISS_W-1:0] miss_calc;
    logic              alive_calc;
    logic [TIME_W-1:0] gap;
    logic              hit;
    logic              ptr_last;

    assign eff_int    = (interval_reg == '0) ? INT_W'(1) : interval_reg;
    assign gap        = now_reg - seen_reg;
    assign div_gap    = now_reg - rd_time;
    assign alive_calc = gap <= TIME_W'(eff_int);
    assign miss_calc  = (now_reg <= seen_reg) ? '0 :
                        (div_q > TIME_W'(MISS_SAT)) ? MISS_SAT : div_q[MISS_W-1:0];
    assign hit        = (rd_key == key_reg);
    assign ptr_last   = (ptr_reg + CW'(1) == count_reg);
    assign rd_addr    = ptr_reg[AW-1:0];

    hlt_store #(.DEPTH(TABLE_ENTRIES), .AW(AW)) u_store
    (
        .clk        (clk),
        .rd_addr    (rd_addr),
        .rd_key     (rd_key),
        .rd_time    (rd_time),
        .rd_miss    (rd_miss),
        .wr_en      (wr_en),
        .wr_key_en  (wr_key_en),
        .wr_addr    (wr_addr),
        .wr_key     (key_reg),
        .wr_time    (now_reg),
        .wr_miss_en (wr_miss_en),
        .wr_miss    (wr_miss)
    );

    hlt_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_gap),
        .divisor  (eff_int),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    priority if (func == FUNC_BEAT && device_key == '0)
                        state_next = S_SINGLE;
                    else if (func == FUNC_BEAT || func == FUNC_QUERY)
                        state_next = (count_reg == '0) ? S_BEAT_WR : S_SRCH_RD;
                    else if (func == FUNC_TICK)
                        state_next = (count_reg == '0) ? S_SINGLE : S_TICK_RD;
                    else
                        state_next = S_IDLE;
                end
            end
            S_SRCH_RD:   state_next = S_SRCH_CMP;
            S_SRCH_CMP:
            begin
                if (hit)
                    state_next = S_BEAT_WR;
                else if (ptr_last)
                    state_next = S_BEAT_WR;
                else
                    state_next = S_SRCH_RD;
            end
            S_BEAT_WR:   state_next = S_IDLE;
            S_QRY_OUT:   state_next = S_IDLE;
            S_TICK_RD:   state_next = S_TICK_DIV;
            S_TICK_DIV:  state_next = S_TICK_WAIT;
            S_TICK_WAIT: state_next = div_done ? S_TICK_OUT : S_TICK_WAIT;
            S_TICK_OUT:  state_next = ptr_last ? S_IDLE : S_TICK_RD;
            S_SINGLE:    state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    // hit_reg remembers whether the search ended on a match
    logic hit_reg;

    always_comb
    begin
        wr_en      = 1'b0;
        wr_key_en  = 1'b0;
        wr_miss_en = 1'b0;
        wr_addr    = ptr_reg[AW-1:0];
        wr_miss    = '0;
        div_start  = 1'b0;
        unique case (state_reg)
            S_BEAT_WR:
            begin
                if (func_reg == FUNC_BEAT)
                begin
                    if (hit_reg)
                    begin
                        wr_en      = 1'b1;
                        wr_miss_en = 1'b1;
                    end
                    else if (count_reg != FULL_CNT)
                    begin
                        wr_addr    = count_reg[AW-1:0];
                        wr_en      = 1'b1;
                        wr_key_en  = 1'b1;
                        wr_miss_en = 1'b1;
                    end
                end
            end
            S_TICK_DIV: div_start = 1'b1;
            S_TICK_OUT:
            begin
                wr_miss_en = 1'b1;
                wr_miss    = miss_calc;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            interval_reg <= INT_W'(10);
            count_reg    <= '0;
            o_done_reg   <= 1'b0;
            hit_reg      <= 1'b0;
            ptr_reg      <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            o_done_reg <= 1'b0;
            if (cfg_we)
                interval_reg <= cfg_wdata;
            unique case (state_reg)
                S_IDLE:
                begin
                    ptr_reg <= '0;
                    hit_reg <= 1'b0;
                    if (start && state_next == S_SINGLE)
                        o_done_reg <= 1'b1;
                end
                S_SRCH_CMP:
                begin
                    if (hit)
                        hit_reg <= 1'b1;
                    else if (!ptr_last)
                        ptr_reg <= ptr_reg + CW'(1);
                end
                S_BEAT_WR:
                begin
                    o_done_reg <= 1'b1;
                    if (func_reg == FUNC_BEAT && !hit_reg && count_reg != FULL_CNT)
                        count_reg <= count_reg + CW'(1);
                end
                S_TICK_OUT:
                begin
                    o_done_reg <= 1'b1;
                    ptr_reg    <= ptr_reg + CW'(1);
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                func_reg     <= func;
                key_reg      <= device_key;
                now_reg      <= now_time;
                o_idx_reg    <= '0;
                o_miss_reg   <= '0;
                o_seen_reg   <= '0;
                o_alive_reg  <= 1'b0;
                o_last_reg   <= 1'b1;
                o_key_reg    <= '0;
                o_status_reg <= (func == FUNC_TICK) ? ST_EMPTY : ST_INVALID;
            end
            S_SRCH_CMP:
            begin
                skey_reg <= rd_key;
                seen_reg <= rd_time;
                o_miss_reg <= rd_miss;
            end
            S_BEAT_WR:
            begin
                o_last_reg <= 1'b1;
                if (func_reg == FUNC_QUERY)
                begin
                    if (hit_reg)
                    begin
                        o_status_reg <= ST_FOUND;
                        o_idx_reg    <= IDX_W'(ptr_reg);
                        o_key_reg    <= skey_reg;
                        o_seen_reg   <= seen_reg;
                        o_alive_reg  <= (now_reg - seen_reg) <= TIME_W'(eff_int);
                    end
                    else
                    begin
                        o_status_reg <= ST_NOT_FOUND;
                        o_idx_reg    <= '0;
                        o_key_reg    <= '0;
                        o_miss_reg   <= '0;
                        o_seen_reg   <= '0;
                        o_alive_reg  <= 1'b0;
                    end
                end
                else if (hit_reg)
                begin
                    o_status_reg <= ST_REFRESHED;
                    o_idx_reg    <= IDX_W'(ptr_reg);
                    o_key_reg    <= key_reg;
                    o_miss_reg   <= '0;
                    o_seen_reg   <= now_reg;
                    o_alive_reg  <= 1'b1;
                end
                else if (count_reg != FULL_CNT)
                begin
                    o_status_reg <= ST_INSERTED;
                    o_idx_reg    <= IDX_W'(count_reg);
                    o_key_reg    <= key_reg;
                    o_miss_reg   <= '0;
                    o_seen_reg   <= now_reg;
                    o_alive_reg  <= 1'b1;
                end
                else
                begin
                    o_status_reg <= ST_FULL;
                    o_idx_reg    <= '0;
                    o_key_reg    <= key_reg;
                    o_miss_reg   <= '0;
                    o_seen_reg   <= '0;
                    o_alive_reg  <= 1'b0;
                end
            end
            S_TICK_DIV:
            begin
                skey_reg <= rd_key;
                seen_reg <= rd_time;
            end
            S_TICK_OUT:
            begin
                o_status_reg <= ST_SWEEP;
                o_idx_reg    <= IDX_W'(ptr_reg);
                o_key_reg    <= skey_reg;
                o_miss_reg   <= miss_calc;
                o_seen_reg   <= seen_reg;
                o_alive_reg  <= alive_calc;
                o_last_reg   <= ptr_last;
            end
            default: ;
        endcase
    end

    // divider takes its gap straight from the read port
    assign busy        = (state_reg != S_IDLE);
    assign done        = o_done_reg;
    assign status      = o_status_reg;
    assign entry_index = o_idx_reg;
    assign entry_key   = o_key_reg;
    assign miss_total  = o_miss_reg;
    assign last_seen   = o_seen_reg;
    assign alive       = o_alive_reg;
    assign last        = o_last_reg;

endmodule
`default_nettype wire

[rtl/hlt_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hlt_div
// Restoring divider, one quotient bit per cycle, 32-bit by 16-bit.
// ----------------------------------------------------------------------------
module hlt_div
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [hlt_pkg::TIME_W-1:0] dividend,
    input  wire logic [hlt_pkg::INT_W-1:0]  divisor,
    output logic                            done,
    output logic [hlt_pkg::TIME_W-1:0]      quotient
);
    import hlt_pkg::*;

    logic [TIME_W-1:0] q_reg;
    logic [INT_W:0]    rem_reg;
    logic [INT_W-1:0]  dsr_reg;
    logic [5:0]        cnt_reg;
    logic              run_reg;
    logic              done_reg;
    logic [INT_W:0]    shifted;
    logic [INT_W:0]    diff;

    assign shifted = {rem_reg[INT_W-1:0], q_reg[TIME_W-1]};
    assign diff    = shifted - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= 6'(TIME_W);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (run_reg)
        begin
            if (!diff[INT_W])
            begin
                rem_reg <= diff;
                q_reg   <= {q_reg[TIME_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                q_reg   <= {q_reg[TIME_W-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule
`default_nettype wire

[rtl/hlt_store.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hlt_store
// Entry memory: key, last beat and miss count per slot, registered read.
// ----------------------------------------------------------------------------
module hlt_store
#(
    parameter int unsigned DEPTH = 32,
    parameter int unsigned AW    = 5
)
(
    input  wire logic                       clk,
    input  wire logic [AW-1:0]              rd_addr,
    output logic [hlt_pkg::KEY_W-1:0]       rd_key,
    output logic [hlt_pkg::TIME_W-1:0]      rd_time,
    output logic [hlt_pkg::MISS_W-1:0]      rd_miss,
    input  wire logic                       wr_en,
    input  wire logic                       wr_key_en,
    input  wire logic [AW-1:0]              wr_addr,
    input  wire logic [hlt_pkg::KEY_W-1:0]  wr_key,
    input  wire logic [hlt_pkg::TIME_W-1:0] wr_time,
    input  wire logic                       wr_miss_en,
    input  wire logic [hlt_pkg::MISS_W-1:0] wr_miss
);
    import hlt_pkg::*;

    logic [KEY_W-1:0]  key_mem  [DEPTH];
    logic [TIME_W-1:0] time_mem [DEPTH];
    logic [MISS_W-1:0] miss_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en && wr_key_en)
            key_mem[wr_addr] <= wr_key;
        if (wr_en)
            time_mem[wr_addr] <= wr_time;
        if (wr_miss_en)
            miss_mem[wr_addr] <= wr_miss;
        rd_key  <= key_mem[rd_addr];
        rd_time <= time_mem[rd_addr];
        rd_miss <= miss_mem[rd_addr];
    end

endmodule
`default_nettype wire

[rtl/hlt_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hlt_checker
// Port-level checks for the heartbeat liveness table.
// ----------------------------------------------------------------------------
module hlt_port_checks
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       done,
    input wire logic [2:0] status,
    input wire logic       last,
    input wire logic       alive
);
    import hlt_pkg::*;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy || done || $past(start && !busy))
        else $error("accepted item left no trace");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done && last && !start |=> !busy)
        else $error("busy after final result");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != ST_SWEEP |-> last)
        else $error("non-sweep result without last");

    a_dead_alive: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == ST_FULL || status == ST_INVALID || status == ST_NOT_FOUND
                 || status == ST_EMPTY) |-> !alive)
        else $error("alive on an empty result");

endmodule

bind heartbeat_liveness_table hlt_port_checks u_hlt_checker
(
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .status (status),
    .last   (last),
    .alive  (alive)
);
`default_nettype wire

[bench/hlt_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hlt_checker
// Watches the item, result and register ports of the heartbeat liveness table,
// keeps a shadow copy of the table, predicts every result and compares them
// in order.
// ----------------------------------------------------------------------------
module hlt_checker
    import hlt_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic                busy,
    input  wire logic [1:0]          func,
    input  wire logic [KEY_W-1:0]    device_key,
    input  wire logic [TIME_W-1:0]   now_time,
    input  wire logic                cfg_we,
    input  wire logic [INT_W-1:0]    cfg_wdata,
    input  wire logic                done,
    input  wire logic [STAT_W-1:0]   status,
    input  wire logic [IDX_W-1:0]    entry_index,
    input  wire logic [KEY_W-1:0]    entry_key,
    input  wire logic [MISS_W-1:0]   miss_total,
    input  wire logic [TIME_W-1:0]   last_seen,
    input  wire logic                alive,
    input  wire logic                last,
    output int                       errors,
    output int                       pending
);

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [IDX_W-1:0]  index;
        logic [KEY_W-1:0]  key;
        logic [MISS_W-1:0] miss;
        logic [TIME_W-1:0] seen;
        logic              alive;
        logic              last;
    } entry_rsp_t;

    localparam int DEPTH = 32;

    logic [KEY_W-1:0]  shadow_key  [DEPTH];
    logic [TIME_W-1:0] shadow_beat [DEPTH];
    logic [MISS_W-1:0] shadow_miss [DEPTH];
    int                shadow_count;
    logic [INT_W-1:0]  interval;
    entry_rsp_t        expected_rsp [$];

    function automatic logic [31:0] eff_interval();
        return (interval == 0) ? 32'd1 : {16'd0, interval};
    endfunction

    function automatic logic is_alive(logic [31:0] t, logic [31:0] seen);
        logic [31:0] gap;
        gap = t - seen;
        return gap <= eff_interval();
    endfunction

    function automatic int find_key(logic [31:0] k);
        if (k == 0)
            return -1;
        for (int i = 0; i < shadow_count; i++)
            if (shadow_key[i] == k)
                return i;
        return -1;
    endfunction

    function automatic entry_rsp_t mk(status_t s, int i, logic [31:0] k, logic [7:0] m,
                                      logic [31:0] t, logic a, logic l);
        entry_rsp_t r;
        r.status = s;
        r.index  = i[IDX_W-1:0];
        r.key    = k;
        r.miss   = m;
        r.seen   = t;
        r.alive  = a;
        r.last   = l;
        return r;
    endfunction

    task automatic predict_item(logic [1:0] f, logic [31:0] k, logic [31:0] t);
        int          idx;
        logic [31:0] q;
        logic [7:0]  m;
        idx = find_key(k);
        case (f)
            FUNC_BEAT:
                if (k == 0)
                    expected_rsp.push_back(mk(ST_INVALID, 0, 0, 0, 0, 0, 1));
                else if (idx >= 0) begin
                    shadow_beat[idx] = t;
                    shadow_miss[idx] = 0;
                    expected_rsp.push_back(mk(ST_REFRESHED, idx, k, 0, t, 1, 1));
                end
                else if (shadow_count < DEPTH) begin
                    shadow_key[shadow_count]  = k;
                    shadow_beat[shadow_count] = t;
                    shadow_miss[shadow_count] = 0;
                    expected_rsp.push_back(mk(ST_INSERTED, shadow_count, k, 0, t, 1, 1));
                    shadow_count++;
                end
                else
                    expected_rsp.push_back(mk(ST_FULL, 0, k, 0, 0, 0, 1));
            FUNC_TICK:
                if (shadow_count == 0)
                    expected_rsp.push_back(mk(ST_EMPTY, 0, 0, 0, 0, 0, 1));
                else
                    for (int i = 0; i < shadow_count; i++) begin
                        m = 0;
                        if (t > shadow_beat[i]) begin
                            q = (t - shadow_beat[i]) / eff_interval();
                            m = (q > 255) ? MISS_SAT : q[7:0];
                        end
                        shadow_miss[i] = m;
                        expected_rsp.push_back(mk(ST_SWEEP, i, shadow_key[i], m,
                            shadow_beat[i], is_alive(t, shadow_beat[i]),
                            i == shadow_count - 1));
                    end
            FUNC_QUERY:
                if (idx < 0)
                    expected_rsp.push_back(mk(ST_NOT_FOUND, 0, 0, 0, 0, 0, 1));
                else
                    expected_rsp.push_back(mk(ST_FOUND, idx, shadow_key[idx],
                        shadow_miss[idx], shadow_beat[idx],
                        is_alive(t, shadow_beat[idx]), 1));
            default: ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        entry_rsp_t got;
        entry_rsp_t want;
        if (!rst_n) begin
            shadow_count = 0;
            interval     = 16'd10;
            errors       = 0;
            expected_rsp.delete();
        end
        else begin
            if (done) begin
                got = mk(status_t'(status), entry_index, entry_key, miss_total,
                         last_seen, alive, last);
                if (expected_rsp.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    errors++;
                end
                else begin
                    want = expected_rsp.pop_front();
                    if (got.status != want.status)
                        $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
                    if (got.index != want.index)
                        $display("%0t: entry_index exp %0d got %0d", $time, want.index,
                                 got.index);
                    if (got.key != want.key)
                        $display("%0t: entry_key exp %h got %h", $time, want.key, got.key);
                    if (got.miss != want.miss)
                        $display("%0t: miss_total exp %0d got %0d", $time, want.miss,
                                 got.miss);
                    if (got.seen != want.seen)
                        $display("%0t: last_seen exp %h got %h", $time, want.seen, got.seen);
                    if (got.alive != want.alive)
                        $display("%0t: alive exp %b got %b", $time, want.alive, got.alive);
                    if (got.last != want.last)
                        $display("%0t: last exp %b got %b", $time, want.last, got.last);
                    if (got != want)
                        errors++;
                end
            end
            if (cfg_we)
                interval = cfg_wdata;
            if (start && !busy)
                predict_item(func, device_key, now_time);
        end
        pending = expected_rsp.size();
    end

endmodule

[bench/heartbeat_liveness_table_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// heartbeat_liveness_table_tb
// Drives directed and random beat, tick, query and unused-code items through the table
// under several beat intervals and sender gap rates; the checker predicts and
// compares every result.
// ----------------------------------------------------------------------------
module heartbeat_liveness_table_tb;
    import hlt_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [1:0]        func;
    logic [KEY_W-1:0]  device_key;
    logic [TIME_W-1:0] now_time;
    logic              cfg_we;
    logic [INT_W-1:0]  cfg_wdata;
    logic              done;
    logic [STAT_W-1:0] status;
    logic [IDX_W-1:0]  entry_index;
    logic [KEY_W-1:0]  entry_key;
    logic [MISS_W-1:0] miss_total;
    logic [TIME_W-1:0] last_seen;
    logic              alive;
    logic              last;
    int                errors;
    int                pending;
    int                idle_cycles;
    int                gap_pct;
    logic [31:0]       key_pool [40];
    logic [31:0]       clock_now;

    heartbeat_liveness_table dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .func(func),
        .device_key(device_key), .now_time(now_time), .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata), .done(done), .status(status),
        .entry_index(entry_index), .entry_key(entry_key), .miss_total(miss_total),
        .last_seen(last_seen), .alive(alive), .last(last)
    );

    hlt_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .func(func),
        .device_key(device_key), .now_time(now_time), .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata), .done(done), .status(status),
        .entry_index(entry_index), .entry_key(entry_key), .miss_total(miss_total),
        .last_seen(last_seen), .alive(alive), .last(last),
        .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send(func_t f, logic [31:0] k, logic [31:0] t);
        if ($urandom_range(99) < gap_pct) begin
            start = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        while (busy) begin
            start = 1'b0;
            @(negedge clk);
        end
        func       = f;
        device_key = k;
        now_time   = t;
        start      = 1'b1;
        @(negedge clk);
    endtask

    task automatic drain();
        start = 1'b0;
        @(negedge clk);
        while (busy || pending != 0)
            @(negedge clk);
        repeat (80) @(negedge clk);
    endtask

    task automatic set_interval(logic [15:0] v);
        drain();
        cfg_we    = 1'b1;
        cfg_wdata = v;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    task automatic random_items(int n);
        int          sel;
        logic [31:0] k;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(99);
            k = key_pool[$urandom_range(39)];
            if ($urandom_range(19) == 0)
                k = $urandom();
            if ($urandom_range(29) == 0)
                k = 0;
            clock_now += $urandom_range(0, 40);
            if (sel < 55)
                send(FUNC_BEAT, k, clock_now - $urandom_range(0, 20));
            else if (sel < 68)
                send(FUNC_TICK, $urandom(), ($urandom_range(9) == 0) ? $urandom()
                     : clock_now + $urandom_range(0, 3000));
            else if (sel < 97)
                send(FUNC_QUERY, k, ($urandom_range(9) == 0) ? $urandom()
                     : clock_now + $urandom_range(0, 30));
            else begin
                send(FUNC_NONE, $urandom(), $urandom());
                i--;
            end
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        func        = FUNC_BEAT;
        device_key  = '0;
        now_time    = '0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        idle_cycles = 0;
        gap_pct     = 17;
        clock_now   = 32'h1000;
        for (int i = 0; i < 40; i++)
            key_pool[i] = $urandom() | 32'd1;
        key_pool[0] = 32'hFFFF_FFFF;
        key_pool[1] = 32'd1;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send(FUNC_TICK, 0, 32'd5);
        send(FUNC_BEAT, 0, 32'd7);
        send(FUNC_QUERY, 0, 32'd7);
        send(FUNC_QUERY, 32'd55, 32'd7);
        send(FUNC_BEAT, 32'hFFFF_FFFF, 32'd0);
        send(FUNC_BEAT, 32'd1, 32'hFFFF_FFFF);
        send(FUNC_BEAT, 32'hA5A5_5A5A, 32'd100);
        send(FUNC_NONE, 32'd1, 32'd3);
        send(FUNC_QUERY, 32'd1, 32'd4);
        send(FUNC_QUERY, 32'hFFFF_FFFF, 32'd10);
        send(FUNC_QUERY, 32'hFFFF_FFFF, 32'd11);
        send(FUNC_TICK, 0, 32'd0);
        send(FUNC_TICK, 0, 32'hFFFF_FFFF);
        send(FUNC_QUERY, 32'hA5A5_5A5A, 32'd50);
        send(FUNC_BEAT, 32'hFFFF_FFFF, 32'd200);
        send(FUNC_TICK, 0, 32'd215);
        send(FUNC_QUERY, 32'd1, 32'd300);

        set_interval(16'd1);
        random_items(150);
        set_interval(16'hFFFF);
        gap_pct = 64;
        random_items(150);
        set_interval(16'($urandom_range(2, 200)));
        gap_pct = 0;
        random_items(150);
        drain();

        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
